### src/pmst_pkg.sv
// Shared constants and types of the Prim minimum spanning tree block.
// No dependencies; compile this file first.
`timescale 1ns / 1ps

package pmst_pkg;

	localparam int MAX_VERTICES = 32;
	localparam int MAX_EDGES    = 256;
	localparam int WEIGHT_BITS  = 16;

	localparam int VERT_W    = $clog2(MAX_VERTICES);
	localparam int CFG_W     = 6;
	localparam int EDGE_AW   = $clog2(MAX_EDGES);
	localparam int EDGE_CW   = $clog2(MAX_EDGES + 1);
	localparam int EDGE_DW   = WEIGHT_BITS + 2 * VERT_W;
	localparam int TREE_DW   = WEIGHT_BITS + 2 * VERT_W;
	localparam int IN_WGT_W  = 16;
	localparam int IN_VERT_W = 5;
	localparam int STATUS_W  = 2;

	typedef enum logic [STATUS_W-1:0] {
		STATUS_OK           = 2'd0,
		STATUS_DISCONNECTED = 2'd1,
		STATUS_OVERFLOW     = 2'd2
	} status_t;

endpackage

### src/pmst_edge_if.sv
// Input channel of the spanning tree block: one weighted edge per item.
// Depends on pmst_pkg.
`timescale 1ns / 1ps

interface pmst_edge_if import pmst_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [IN_WGT_W-1:0]  edge_weight;
	logic [IN_VERT_W-1:0] end_first;
	logic [IN_VERT_W-1:0] end_second;
	logic                 last_edge;

	modport source (output valid, edge_weight, end_first, end_second, last_edge, input ready);
	modport sink (input valid, edge_weight, end_first, end_second, last_edge, output ready);
endinterface

### src/pmst_tree_if.sv
// Output channel of the spanning tree block: one tree edge or error per item.
// Depends on pmst_pkg.
`timescale 1ns / 1ps

interface pmst_tree_if import pmst_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [IN_WGT_W-1:0]  tree_weight;
	logic [IN_VERT_W-1:0] tree_end_first;
	logic [IN_VERT_W-1:0] tree_end_second;
	logic [STATUS_W-1:0]  status;
	logic                 last_result;

	modport source (output valid, tree_weight, tree_end_first, tree_end_second, status,
		last_result, input ready);
	modport sink (input valid, tree_weight, tree_end_first, tree_end_second, status,
		last_result, output ready);
endinterface

### src/pmst_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module pmst_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### src/prim_minimum_spanning_tree_top.sv
// Top level of the Prim minimum spanning tree block over a stored edge list.
// Depends on pmst_pkg, pmst_edge_if, pmst_tree_if and pmst_ram.
//
//   Channel    Dir  Handshake      Carries
//   edges      in   valid/ready    edge_weight, end_first, end_second, last_edge
//   tree       out  valid/ready    tree_weight, tree_end_first, tree_end_second,
//                                  status, last_result
//   cfg        in   cfg_we         cfg_wdata = vertex_count
//
// Edges load at one item per cycle while the block is in its load state. After the last
// edge comes a start state, and then each tree edge costs one scan of the edge RAM,
// which reads the stored edges one at a time through its single read port, plus a drain
// and a decide state. Every tree edge of a connected run then passes through a read and
// a load state on the chosen-edge RAM.
// Reset clears control state only; the stores need no clearing pass, since only
// entries below the fill count are read. A held result stalls only the output
// path; new edges are accepted as soon as the last result of a run is registered.
`timescale 1ns / 1ps

module prim_minimum_spanning_tree_top import pmst_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [CFG_W-1:0] cfg_wdata,
	pmst_edge_if.sink        edges,
	pmst_tree_if.source      tree
);

	typedef enum logic [6:0] {
		S_LOAD   = 7'b0000001,
		S_START  = 7'b0000010,
		S_SCAN   = 7'b0000100,
		S_DRAIN  = 7'b0001000,
		S_DECIDE = 7'b0010000,
		S_OUT_RD = 7'b0100000,
		S_OUT_LD = 7'b1000000
	} state_t;

	state_t                   state_q;
	logic [CFG_W-1:0]         vertex_count_q;
	logic [EDGE_CW-1:0]       count_q;
	logic                     overflow_q;
	logic [MAX_VERTICES-1:0]  visited_q;
	logic [EDGE_AW-1:0]       rd_q;
	logic                     valid_s1;
	logic                     first_q;
	logic                     have_q;
	logic [WEIGHT_BITS-1:0]   best_w_q;
	logic [VERT_W-1:0]        best_a_q;
	logic [VERT_W-1:0]        best_b_q;
	logic [VERT_W-1:0]        best_v_q;
	logic [VERT_W-1:0]        n_q;
	logic [VERT_W-1:0]        o_q;

	logic                     out_valid_q;
	logic [IN_WGT_W-1:0]      out_w_q;
	logic [IN_VERT_W-1:0]     out_a_q;
	logic [IN_VERT_W-1:0]     out_b_q;
	status_t                  out_status_q;
	logic                     out_last_q;

	logic [CFG_W-1:0]         nv;
	logic [MAX_VERTICES-1:0]  all_mask;
	logic [MAX_VERTICES-1:0]  vis_next;

	logic                     in_take;
	logic                     e_we;
	logic [EDGE_DW-1:0]       e_wdata;
	logic [EDGE_DW-1:0]       e_rdata;
	logic                     c_we;
	logic                     c_re;
	logic [TREE_DW-1:0]       c_wdata;
	logic [TREE_DW-1:0]       c_rdata;

	logic [WEIGHT_BITS-1:0]   rd_w;
	logic [VERT_W-1:0]        rd_a;
	logic [VERT_W-1:0]        rd_b;
	logic                     vis_a;
	logic                     vis_b;
	logic                     in_range;
	logic                     cand;
	logic [VERT_W-1:0]        vend;
	logic                     better;

	// Vertex count as used: clamped to 2..MAX_VERTICES.
	always_comb begin
		if (vertex_count_q < CFG_W'(2)) begin
			nv = CFG_W'(2);
		end else if (vertex_count_q > CFG_W'(MAX_VERTICES)) begin
			nv = CFG_W'(MAX_VERTICES);
		end else begin
			nv = vertex_count_q;
		end
	end

	always_comb begin
		for (int i = 0; i < MAX_VERTICES; i++) begin
			all_mask[i] = (CFG_W'(i) < nv);
		end
	end

	assign in_take = edges.valid && edges.ready;
	assign edges.ready = (state_q == S_LOAD);

	assign e_we = in_take && (edges.end_first != edges.end_second)
		&& (count_q < EDGE_CW'(MAX_EDGES));
	assign e_wdata = {VERT_W'(edges.end_second), VERT_W'(edges.end_first),
		WEIGHT_BITS'(edges.edge_weight)};

	pmst_ram #(.WIDTH(EDGE_DW), .DEPTH(MAX_EDGES)) u_edge_ram (
		.clk   (clk),
		.we    (e_we),
		.waddr (count_q[EDGE_AW-1:0]),
		.wdata (e_wdata),
		.re    (state_q == S_SCAN),
		.raddr (rd_q),
		.rdata (e_rdata)
	);

	// Chosen tree edges are held here until the run is known to be connected.
	assign c_we    = (state_q == S_DECIDE) && have_q;
	assign c_wdata = {best_b_q, best_a_q, best_w_q};
	assign c_re    = (state_q == S_OUT_RD) && !out_valid_q;

	pmst_ram #(.WIDTH(TREE_DW), .DEPTH(MAX_VERTICES)) u_chosen_ram (
		.clk   (clk),
		.we    (c_we),
		.waddr (n_q),
		.wdata (c_wdata),
		.re    (c_re),
		.raddr (o_q),
		.rdata (c_rdata)
	);

	// Candidate test on the edge just read. Past the first pick, within one weight the lower
	// visited endpoint wins; otherwise the earlier edge wins through the strict compare.
	assign rd_w     = e_rdata[WEIGHT_BITS-1:0];
	assign rd_a     = e_rdata[WEIGHT_BITS +: VERT_W];
	assign rd_b     = e_rdata[WEIGHT_BITS + VERT_W +: VERT_W];
	assign vis_a    = visited_q[rd_a];
	assign vis_b    = visited_q[rd_b];
	assign in_range = ({1'b0, rd_a} < nv) && ({1'b0, rd_b} < nv);
	assign cand     = valid_s1 && in_range && (first_q || (vis_a ^ vis_b));
	assign vend     = vis_a ? rd_a : rd_b;
	assign better   = !have_q || (rd_w < best_w_q)
		|| (!first_q && (rd_w == best_w_q) && (vend < best_v_q));

	assign vis_next = visited_q | (MAX_VERTICES'(1) << best_a_q)
		| (MAX_VERTICES'(1) << best_b_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_LOAD;
			vertex_count_q <= CFG_W'(32);
			count_q        <= '0;
			overflow_q     <= 1'b0;
			visited_q      <= '0;
			rd_q           <= '0;
			valid_s1       <= 1'b0;
			first_q        <= 1'b0;
			have_q         <= 1'b0;
			n_q            <= '0;
			o_q            <= '0;
			out_valid_q    <= 1'b0;
			out_status_q   <= STATUS_OK;
			out_last_q     <= 1'b0;
		end else begin
			if (cfg_we) begin
				vertex_count_q <= cfg_wdata;
			end
			if (tree.valid && tree.ready) begin
				out_valid_q <= 1'b0;
			end
			valid_s1 <= (state_q == S_SCAN);
			if (cand && better) begin
				have_q <= 1'b1;
			end

			case (state_q)
				S_LOAD: begin
					if (in_take) begin
						if (edges.end_first != edges.end_second) begin
							if (count_q < EDGE_CW'(MAX_EDGES)) begin
								count_q <= count_q + EDGE_CW'(1);
							end else begin
								overflow_q <= 1'b1;
							end
						end
						if (edges.last_edge) begin
							state_q <= S_START;
						end
					end
				end
				S_START: begin
					if (overflow_q || count_q == '0) begin
						if (!out_valid_q) begin
							out_valid_q  <= 1'b1;
							out_status_q <= overflow_q ? STATUS_OVERFLOW : STATUS_DISCONNECTED;
							out_last_q   <= 1'b1;
							count_q      <= '0;
							overflow_q   <= 1'b0;
							visited_q    <= '0;
							state_q      <= S_LOAD;
						end
					end else begin
						visited_q <= '0;
						first_q   <= 1'b1;
						have_q    <= 1'b0;
						n_q       <= '0;
						rd_q      <= '0;
						state_q   <= S_SCAN;
					end
				end
				S_SCAN: begin
					rd_q <= rd_q + EDGE_AW'(1);
					if ({1'b0, rd_q} == count_q - EDGE_CW'(1)) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					state_q <= S_DECIDE;
				end
				S_DECIDE: begin
					if (!have_q) begin
						if (!out_valid_q) begin
							out_valid_q  <= 1'b1;
							out_status_q <= STATUS_DISCONNECTED;
							out_last_q   <= 1'b1;
							count_q      <= '0;
							overflow_q   <= 1'b0;
							visited_q    <= '0;
							state_q      <= S_LOAD;
						end
					end else begin
						visited_q <= vis_next;
						n_q       <= n_q + VERT_W'(1);
						first_q   <= 1'b0;
						have_q    <= 1'b0;
						rd_q      <= '0;
						o_q       <= '0;
						if ((vis_next & all_mask) == all_mask) begin
							state_q <= S_OUT_RD;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_OUT_RD: begin
					if (!out_valid_q) begin
						state_q <= S_OUT_LD;
					end
				end
				S_OUT_LD: begin
					out_valid_q  <= 1'b1;
					out_status_q <= STATUS_OK;
					out_last_q   <= (o_q == n_q - VERT_W'(1));
					if (o_q == n_q - VERT_W'(1)) begin
						count_q    <= '0;
						overflow_q <= 1'b0;
						visited_q  <= '0;
						state_q    <= S_LOAD;
					end else begin
						o_q     <= o_q + VERT_W'(1);
						state_q <= S_OUT_RD;
					end
				end
				default: begin
					state_q <= S_LOAD;
				end
			endcase
		end
	end

	// Best-edge and result payload registers carry no reset.
	always_ff @(posedge clk) begin
		if (cand && better) begin
			best_w_q <= rd_w;
			best_a_q <= rd_a;
			best_b_q <= rd_b;
			best_v_q <= vend;
		end
		if (state_q == S_OUT_LD) begin
			out_w_q <= IN_WGT_W'(c_rdata[WEIGHT_BITS-1:0]);
			out_a_q <= IN_VERT_W'(c_rdata[WEIGHT_BITS +: VERT_W]);
			out_b_q <= IN_VERT_W'(c_rdata[WEIGHT_BITS + VERT_W +: VERT_W]);
		end else if (state_q == S_START || state_q == S_DECIDE) begin
			if (!out_valid_q && (state_q == S_START || !have_q)) begin
				out_w_q <= '0;
				out_a_q <= '0;
				out_b_q <= '0;
			end
		end
	end

	assign tree.valid           = out_valid_q;
	assign tree.tree_weight     = out_w_q;
	assign tree.tree_end_first  = out_a_q;
	assign tree.tree_end_second = out_b_q;
	assign tree.status          = out_status_q;
	assign tree.last_result     = out_last_q;

	a_scan_in_store: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> ({1'b0, rd_q} < count_q))
		else $error("edge scan reads beyond the fill count");

	a_cut_edge: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DECIDE && have_q && !first_q)
		|-> (visited_q[best_a_q] != visited_q[best_b_q]))
		else $error("chosen edge does not cross the visited cut");

	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUT_LD) |-> !out_valid_q)
		else $error("tree edge loaded over a pending result");

	a_tree_size: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DECIDE && have_q) |-> ({1'b0, n_q} < nv - CFG_W'(1)))
		else $error("more tree edges than vertices allow");

	a_new_vertex: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DECIDE && have_q) |=> ($countones(visited_q) > $countones($past(visited_q))))
		else $error("tree step added no vertex");

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for prim_minimum_spanning_tree_top: loads edge lists, predicts the tree
// edges of every graph in step with the block, and checks each result item against them.
// Depends on pmst_pkg, pmst_edge_if, pmst_tree_if and the block's RTL.

module testbench;
	import pmst_pkg::*;

	localparam int SETTLE         = 20;
	localparam int WATCHDOG_LIMIT = 40000;
	localparam int RANDOM_ITEMS   = 150;
	localparam int NO_CFG         = -1;

	typedef struct packed {
		logic [IN_WGT_W-1:0]  weight;
		logic [IN_VERT_W-1:0] first;
		logic [IN_VERT_W-1:0] second;
		logic                 last;
	} edge_item_t;

	typedef struct {
		logic [IN_WGT_W-1:0]  weight;
		logic [IN_VERT_W-1:0] first;
		logic [IN_VERT_W-1:0] second;
		status_t              status;
		logic                 last;
	} tree_item_t;

	typedef struct {
		int         cfg;
		edge_item_t item;
		bit         typed;
		tree_item_t result;
	} table_row_t;

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic [CFG_W-1:0] cfg_wdata;

	pmst_edge_if edges ();
	pmst_tree_if tree ();

	prim_minimum_spanning_tree_top uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.edges     (edges),
		.tree      (tree)
	);

	// Shadow copy of the edge store and the vertex count.
	logic [IN_WGT_W-1:0]  graph_weight [MAX_EDGES];
	logic [IN_VERT_W-1:0] graph_first [MAX_EDGES];
	logic [IN_VERT_W-1:0] graph_second [MAX_EDGES];
	int                   graph_size;
	bit                   graph_overflow;
	logic [CFG_W-1:0]     vertex_cfg;

	tree_item_t pending_tree[$];
	table_row_t directed[$];
	edge_item_t graph_edges[$];
	int         errors;
	bit         steady;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int active_vertices();
		if (vertex_cfg < 2)
			return 2;
		if (vertex_cfg > MAX_VERTICES)
			return MAX_VERTICES;
		return int'(vertex_cfg);
	endfunction

	function automatic void push_tree(int w, int a, int b, status_t st, bit last);
		tree_item_t t;
		t.weight = IN_WGT_W'(w);
		t.first = IN_VERT_W'(a);
		t.second = IN_VERT_W'(b);
		t.status = st;
		t.last = last;
		pending_tree = {pending_tree, t};
	endfunction

	// Prim's method over the shadow store; ties fall to the lower visited vertex,
	// then to the earlier stored edge, because only a strictly cheaper edge replaces.
	function automatic void emit_tree();
		int                      nv;
		int                      found;
		int                      best;
		int                      picks[$];
		bit                      have;
		bit                      broken;
		logic [MAX_VERTICES-1:0] seen;
		logic [MAX_VERTICES-1:0] everyone;
		nv = active_vertices();
		everyone = '0;
		seen = '0;
		broken = 1'b0;
		for (int v = 0; v < nv; v++)
			everyone[v] = 1'b1;
		if (graph_overflow) begin
			push_tree(0, 0, 0, STATUS_OVERFLOW, 1'b1);
		end else begin
			found = -1;
			for (int e = 0; e < graph_size; e++) begin
				if (graph_first[e] >= nv || graph_second[e] >= nv)
					continue;
				if (found < 0 || graph_weight[e] < graph_weight[found])
					found = e;
			end
			if (found < 0) begin
				broken = 1'b1;
			end else begin
				picks = {picks, found};
				seen[graph_first[found]] = 1'b1;
				seen[graph_second[found]] = 1'b1;
			end
			while (!broken && seen != everyone) begin
				have = 1'b0;
				best = 0;
				for (int v = 0; v < nv; v++) begin
					if (!seen[v])
						continue;
					for (int e = 0; e < graph_size; e++) begin
						if (graph_first[e] >= nv || graph_second[e] >= nv)
							continue;
						if (graph_first[e] != v && graph_second[e] != v)
							continue;
						if (seen[graph_first[e]] && seen[graph_second[e]])
							continue;
						if (!have || graph_weight[e] < graph_weight[best]) begin
							best = e;
							have = 1'b1;
						end
					end
				end
				if (!have) begin
					broken = 1'b1;
				end else begin
					picks = {picks, best};
					seen[graph_first[best]] = 1'b1;
					seen[graph_second[best]] = 1'b1;
				end
			end
			if (broken) begin
				push_tree(0, 0, 0, STATUS_DISCONNECTED, 1'b1);
			end else begin
				foreach (picks[k])
					push_tree(graph_weight[picks[k]], graph_first[picks[k]],
						graph_second[picks[k]], STATUS_OK, k == picks.size() - 1);
			end
		end
		graph_size = 0;
		graph_overflow = 1'b0;
	endfunction

	function automatic void absorb_edge(edge_item_t it);
		if (it.first != it.second) begin
			if (graph_size < MAX_EDGES) begin
				graph_weight[graph_size] = it.weight;
				graph_first[graph_size] = it.first;
				graph_second[graph_size] = it.second;
				graph_size++;
			end else begin
				graph_overflow = 1'b1;
			end
		end
		if (it.last)
			emit_tree();
	endfunction

	function automatic int pick_gap();
		int r;
		if (steady)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(4, 30);
	endfunction

	function automatic int pick_weight();
		// Narrow weights most of the time so that ties are common.
		if ($urandom_range(0, 3) == 0)
			return $urandom_range(0, 65535);
		return $urandom_range(0, 7);
	endfunction

	function automatic int pick_cfg();
		case ($urandom_range(0, 9))
			0: return 0;
			1: return 1;
			2: return 63;
			3: return 32;
			4: return $urandom_range(33, 63);
			5: return $urandom_range(0, 63);
			default: return $urandom_range(2, 8);
		endcase
	endfunction

	function automatic edge_item_t random_edge(int nv, bit last);
		edge_item_t t;
		t.weight = IN_WGT_W'(pick_weight());
		t.first = IN_VERT_W'($urandom_range(0, nv - 1));
		do
			t.second = IN_VERT_W'($urandom_range(0, nv - 1));
		while (t.second == t.first);
		t.last = last;
		return t;
	endfunction

	// Mostly connected graphs: a random tree over all active vertices plus extra edges,
	// in shuffled order. The rest are loose edge sets that are usually disconnected.
	function automatic void make_graph(int nv);
		edge_item_t t;
		int         extra;
		int         j;
		graph_edges.delete();
		if ($urandom_range(0, 3) != 0) begin
			for (int k = 1; k < nv; k++) begin
				t = random_edge(nv, 1'b0);
				t.first = IN_VERT_W'(k);
				t.second = IN_VERT_W'($urandom_range(0, k - 1));
				graph_edges = {graph_edges, t};
			end
			extra = $urandom_range(0, nv);
		end else begin
			extra = $urandom_range(1, 8);
		end
		repeat (extra)
			graph_edges = {graph_edges, random_edge(nv, 1'b0)};
		if ($urandom_range(0, 4) == 0) begin
			t = random_edge(nv, 1'b0);
			t.first = IN_VERT_W'($urandom_range(0, 31));
			t.second = t.first;
			graph_edges = {graph_edges, t};
		end
		if (nv < MAX_VERTICES && $urandom_range(0, 4) == 0) begin
			t = random_edge(nv, 1'b0);
			t.second = IN_VERT_W'($urandom_range(nv, 31));
			graph_edges = {graph_edges, t};
		end
		for (int k = graph_edges.size() - 1; k > 0; k--) begin
			j = $urandom_range(0, k);
			t = graph_edges[k];
			graph_edges[k] = graph_edges[j];
			graph_edges[j] = t;
		end
		foreach (graph_edges[k]) begin
			if ($urandom_range(0, 1) == 1) begin
				t = graph_edges[k];
				graph_edges[k].first = t.second;
				graph_edges[k].second = t.first;
			end
		end
		graph_edges[graph_edges.size() - 1].last = 1'b1;
	endfunction

	function automatic void add_row(int cfg, int w, int a, int b, bit last, bit typed = 1'b0,
			int tw = 0, int ta = 0, int tb = 0, status_t st = STATUS_OK);
		table_row_t row;
		row.cfg = cfg;
		row.item.weight = IN_WGT_W'(w);
		row.item.first = IN_VERT_W'(a);
		row.item.second = IN_VERT_W'(b);
		row.item.last = last;
		row.typed = typed;
		row.result.weight = IN_WGT_W'(tw);
		row.result.first = IN_VERT_W'(ta);
		row.result.second = IN_VERT_W'(tb);
		row.result.status = st;
		row.result.last = 1'b1;
		directed = {directed, row};
	endfunction

	function automatic void build_table();
		// After reset all 32 vertices count, so one edge cannot span them.
		add_row(NO_CFG, 5, 0, 1, 1, 1, 0, 0, 0, STATUS_DISCONNECTED);
		add_row(2, 16'hFFFF, 0, 1, 1, 1, 16'hFFFF, 0, 1, STATUS_OK);
		add_row(NO_CFG, 0, 1, 0, 1, 1, 0, 1, 0, STATUS_OK);
		// A lone self-loop is dropped but still starts the run.
		add_row(NO_CFG, 7, 1, 1, 1, 1, 0, 0, 0, STATUS_DISCONNECTED);
		add_row(NO_CFG, 3, 0, 31, 1, 1, 0, 0, 0, STATUS_DISCONNECTED);
		// Vertex counts below two and above 32 are clamped.
		add_row(0, 9, 0, 1, 1, 1, 9, 0, 1, STATUS_OK);
		add_row(63, 1, 31, 30, 1, 1, 0, 0, 0, STATUS_DISCONNECTED);
		add_row(1, 16'h5555, 1, 0, 0);
		add_row(NO_CFG, 16'hAAAA, 0, 1, 1);
		// Equal weights everywhere, ended by a self-loop.
		add_row(3, 4, 0, 1, 0);
		add_row(NO_CFG, 4, 1, 2, 0);
		add_row(NO_CFG, 4, 0, 2, 0);
		add_row(NO_CFG, 4, 2, 1, 0);
		add_row(NO_CFG, 2, 2, 2, 1);
		add_row(4, 10, 3, 2, 0);
		add_row(NO_CFG, 1, 0, 1, 0);
		add_row(NO_CFG, 5, 1, 2, 0);
		add_row(NO_CFG, 5, 0, 2, 0);
		add_row(NO_CFG, 7, 2, 3, 1);
		// Two components: the partial tree is discarded.
		add_row(5, 1, 0, 1, 0);
		add_row(NO_CFG, 2, 1, 2, 0);
		add_row(NO_CFG, 3, 3, 4, 1, 1, 0, 0, 0, STATUS_DISCONNECTED);
	endfunction

	task automatic send_edge(edge_item_t it);
		int gap;
		gap = pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			edges.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		edges.valid = 1'b1;
		edges.edge_weight = it.weight;
		edges.end_first = it.first;
		edges.end_second = it.second;
		edges.last_edge = it.last;
		do
			@(posedge clk);
		while (edges.ready !== 1'b1);
	endtask

	task automatic deliver(edge_item_t it);
		send_edge(it);
		absorb_edge(it);
	endtask

	task automatic release_edges();
		@(negedge clk);
		edges.valid = 1'b0;
	endtask

	// The register may only change while the block is idle between graphs.
	task automatic set_vertex_count(int value);
		release_edges();
		while (pending_tree.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_wdata = value[CFG_W-1:0];
		@(negedge clk);
		cfg_we = 1'b0;
		vertex_cfg = value[CFG_W-1:0];
	endtask

	initial begin
		int         mark;
		int         counted;
		int         nv;
		edge_item_t t;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		edges.valid = 1'b0;
		edges.edge_weight = '0;
		edges.end_first = '0;
		edges.end_second = '0;
		edges.last_edge = 1'b0;
		errors = 0;
		steady = 1'b0;
		vertex_cfg = 6'd32;
		graph_size = 0;
		graph_overflow = 1'b0;
		counted = 0;
		build_table();
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (directed[i]) begin
			if (directed[i].cfg != NO_CFG)
				set_vertex_count(directed[i].cfg);
			send_edge(directed[i].item);
			mark = pending_tree.size();
			absorb_edge(directed[i].item);
			if (directed[i].typed) begin
				while (pending_tree.size() > mark)
					void'(pending_tree.pop_back());
				pending_tree = {pending_tree, directed[i].result};
			end
		end

		// One edge more than the store holds.
		set_vertex_count(4);
		steady = ($urandom_range(0, 1) == 0);
		for (int k = 0; k <= MAX_EDGES; k++)
			deliver(random_edge(4, k == MAX_EDGES));

		// A full store is still fine; the closing self-loop is dropped.
		set_vertex_count(32);
		steady = ($urandom_range(0, 1) == 0);
		for (int k = 0; k < MAX_EDGES; k++)
			deliver(random_edge(32, 1'b0));
		t = random_edge(32, 1'b1);
		t.second = t.first;
		deliver(t);

		while (counted < RANDOM_ITEMS) begin
			if ($urandom_range(0, 9) < 4)
				set_vertex_count(pick_cfg());
			nv = active_vertices();
			steady = ($urandom_range(0, 4) == 0);
			make_graph(nv);
			foreach (graph_edges[k]) begin
				deliver(graph_edges[k]);
				if (graph_edges[k].first != graph_edges[k].second &&
						graph_edges[k].first < nv && graph_edges[k].second < nv)
					counted++;
			end
		end

		release_edges();
		while (pending_tree.size() != 0)
			@(posedge clk);
		repeat (3 * SETTLE) @(posedge clk);
		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	// Result side: ready drops for stretches of random length.
	initial begin
		int stall;
		stall = 0;
		tree.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (stall > 0) begin
				tree.ready = 1'b0;
				stall--;
			end else begin
				tree.ready = 1'b1;
				if ($urandom_range(0, 2) == 0)
					stall = pick_gap();
			end
		end
	end

	always @(posedge clk) begin : check_tree
		tree_item_t want;
		if (arst_n && tree.valid === 1'b1 && tree.ready === 1'b1) begin
			if (pending_tree.size() == 0) begin
				$display("%0t: unexpected tree item: weight %0d ends %0d-%0d status %0d last %0d",
					$time, tree.tree_weight, tree.tree_end_first, tree.tree_end_second,
					tree.status, tree.last_result);
				errors++;
			end else begin
				want = pending_tree.pop_front();
				if (want.weight !== tree.tree_weight || want.first !== tree.tree_end_first ||
						want.second !== tree.tree_end_second || want.status !== tree.status ||
						want.last !== tree.last_result) begin
					$display("%0t: tree item mismatch: expected w %0d %0d-%0d st %0d last %0d, %s",
						$time, want.weight, want.first, want.second, want.status, want.last,
						$sformatf("actual w %0d %0d-%0d st %0d last %0d", tree.tree_weight,
						tree.tree_end_first, tree.tree_end_second, tree.status,
						tree.last_result));
					errors++;
				end
			end
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((edges.valid === 1'b1 && edges.ready === 1'b1) ||
					(tree.valid === 1'b1 && tree.ready === 1'b1))
				quiet = 0;
			else
				quiet++;
		end
		$display("%0t: no item moved for %0d cycles", $time, WATCHDOG_LIMIT);
		$display("*** FAILED ***");
		$finish;
	end

endmodule
